/* rtl/ima_adpcm_decoder_core_defines.svh */
// assertion macros for the ima adpcm decoder core
`ifndef IMA_ADPCM_DECODER_CORE_DEFINES_SVH
`define IMA_ADPCM_DECODER_CORE_DEFINES_SVH

// concurrent property on clk, disabled while arst_n is low
`define IMAD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("imad assertion failed");

// a stalled signal keeps its value into the next cycle
`define IMAD_ASSERT_HOLD(lbl, cond, sig) \
	`IMAD_ASSERT(lbl, (cond) |=> $stable(sig))

`endif

/* rtl/imad_pkg.sv */
//------------------------------------------------------------------------------
// imad_pkg
// types, step table and index table of the ima adpcm decoder
//------------------------------------------------------------------------------
package imad_pkg;

	localparam logic [6:0] IDX_MAX = 7'd88;

	localparam logic signed [15:0] PCM_MAX = 16'sh7FFF;
	localparam logic signed [15:0] PCM_MIN = 16'sh8000;

	typedef struct packed {
		logic [3:0] adpcm_code;
		logic       last_code;
	} in_item_t;

	typedef struct packed {
		logic [31:0] stereo_frame;
		logic        last_sample;
	} out_item_t;

	typedef struct packed {
		logic       sign;
		logic [2:0] mag;
		logic       last;
	} cmd_t;

	localparam logic [14:0] STEP_TAB [0:88] = '{
		15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
		15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
		15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
		15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
		15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
		15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
		15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
		15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
		15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
		15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
		15'd27086, 15'd29794, 15'd32767
	};

	localparam logic signed [4:0] IDX_ADJ [0:7] = '{
		-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
	};

endpackage

/* rtl/imad_front.sv */
//------------------------------------------------------------------------------
// imad_front
// accepts code items, splits sign and magnitude, queues them for the back end
//------------------------------------------------------------------------------
module imad_front #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               code_valid,
	output logic               code_ready,
	input  imad_pkg::in_item_t code,
	output logic               cmd_valid,
	input  logic               cmd_pop,
	output imad_pkg::cmd_t     cmd
);
	import imad_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	cmd_t             cmd_in;

	assign code_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign push       = code_valid && code_ready;
	assign cmd_valid  = (count_q != '0);
	assign cmd        = entry_q[rd_ptr_q];

	always_comb begin
		cmd_in.sign = code.adpcm_code[3];
		cmd_in.mag  = code.adpcm_code[2:0];
		cmd_in.last = code.last_code;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/imad_back.sv */
//------------------------------------------------------------------------------
// imad_back
// predictor and step index update, boost, output register
//------------------------------------------------------------------------------
module imad_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_pop,
	input  imad_pkg::cmd_t      cmd,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	output logic                sample_valid,
	input  logic                sample_ready,
	output imad_pkg::out_item_t sample
);
	import imad_pkg::*;

	logic signed [15:0] predictor_q;
	logic [6:0]         step_index_q;
	logic               boost_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic [6:0]         idx_c;
	logic [14:0]        step;
	logic [15:0]        delta;
	logic signed [17:0] sum;
	logic signed [15:0] pred_n;
	logic signed [7:0]  idx_sum;
	logic [6:0]         idx_n;
	logic [15:0]        half;

	assign cmd_pop      = cmd_valid && (!out_valid_q || sample_ready);
	assign sample_valid = out_valid_q;
	assign sample       = out_q;

	always_comb begin
		idx_c = (step_index_q > IDX_MAX) ? IDX_MAX : step_index_q;
		step  = STEP_TAB[idx_c];
		delta = 16'(step >> 3)
			+ (cmd.mag[2] ? 16'(step) : 16'd0)
			+ (cmd.mag[1] ? 16'(step >> 1) : 16'd0)
			+ (cmd.mag[0] ? 16'(step >> 2) : 16'd0);
		sum = cmd.sign ? ({{2{predictor_q[15]}}, predictor_q} - $signed({2'b00, delta}))
			: ({{2{predictor_q[15]}}, predictor_q} + $signed({2'b00, delta}));
		if (sum > 18'sd32767) begin
			pred_n = PCM_MAX;
		end else if (sum < -18'sd32768) begin
			pred_n = PCM_MIN;
		end else begin
			pred_n = sum[15:0];
		end

		idx_sum = $signed({1'b0, idx_c}) + {{3{IDX_ADJ[cmd.mag][4]}}, IDX_ADJ[cmd.mag]};
		if (idx_sum < 8'sd0) begin
			idx_n = '0;
		end else if (idx_sum > $signed({1'b0, IDX_MAX})) begin
			idx_n = IDX_MAX;
		end else begin
			idx_n = idx_sum[6:0];
		end

		if (!boost_q) begin
			half = pred_n;
		end else if (pred_n[15] != pred_n[14]) begin
			half = pred_n[15] ? PCM_MIN : PCM_MAX;
		end else begin
			half = {pred_n[14:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			out_q.stereo_frame <= {half, half};
			out_q.last_sample  <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			predictor_q  <= '0;
			step_index_q <= '0;
			boost_q      <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				boost_q <= cfg_wdata;
			end
			if (cmd_pop) begin
				predictor_q  <= cmd.last ? '0 : pred_n;
				step_index_q <= cmd.last ? '0 : idx_n;
				out_valid_q  <= 1'b1;
			end else if (sample_ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

endmodule

/* rtl/ima_adpcm_decoder_core.sv */
//------------------------------------------------------------------------------
// ima_adpcm_decoder_core
// 4-bit ima adpcm to 16-bit pcm decoder with stereo frame output
//------------------------------------------------------------------------------
// One code item is accepted per clock while code_ready is high and one stereo
// frame comes out per item, so the sustained rate is one item a cycle while
// sample_ready stays high. A frame reaches the sample port once its code has
// been registered in the front queue and then in the output register, which
// the back end's combinational predictor and step index update writes as it
// pops the code. The queue lets codes keep arriving while a frame waits to
// be taken; code_ready drops only when the queue is full. boost_enable
// (cfg_wdata, reset 1) doubles the sample with saturation and should be
// written while idle.
module ima_adpcm_decoder_core #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                code_valid,
	output logic                code_ready,
	input  imad_pkg::in_item_t  code,
	output logic                sample_valid,
	input  logic                sample_ready,
	output imad_pkg::out_item_t sample,
	input  logic                cfg_we,
	input  logic                cfg_wdata
);
	import imad_pkg::*;

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	imad_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.code       (code),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop),
		.cmd        (cmd)
	);

	imad_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_pop      (cmd_pop),
		.cmd          (cmd),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample)
	);

endmodule

/* rtl/imad_checker.sv */
//------------------------------------------------------------------------------
// imad_checker
// port-level checks of the ima adpcm decoder core
//------------------------------------------------------------------------------
`include "ima_adpcm_decoder_core_defines.svh"

module imad_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                code_valid,
	input logic                code_ready,
	input imad_pkg::in_item_t  code,
	input logic                sample_valid,
	input logic                sample_ready,
	input imad_pkg::out_item_t sample
);
	import imad_pkg::*;

	logic code_acc;

	assign code_acc = code_valid && code_ready;

	// a full queue only happens behind a stalled frame
	`IMAD_ASSERT(a_full_implies_out, !code_ready |-> sample_valid)

	// an item taken while the output is empty shows up once it has passed through the front queue and the output register
	`IMAD_ASSERT(a_latency, (code_acc && !sample_valid) |-> ##2 sample_valid)

	// stalled frame keeps valid and payload
	`IMAD_ASSERT(a_valid_hold, (sample_valid && !sample_ready) |=> sample_valid)
	`IMAD_ASSERT_HOLD(a_data_hold, sample_valid && !sample_ready, sample)

	// waiting code item keeps its payload
	`IMAD_ASSERT_HOLD(a_code_hold, code_valid && !code_ready, code)

endmodule

bind ima_adpcm_decoder_core imad_checker u_imad_checker (.*);
